FILE: sv/i2cm_pkg.sv
// Package for the I2C master transfer engine.
// Holds the request codes, default parameter values and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;

  localparam int unsigned LEN_WIDTH_DEF       = 16;
  localparam int unsigned RECOVERY_PULSES_DEF = 9;
  localparam logic [15:0] BIT_DELAY_RESET     = 16'd5;

  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_MSG     = 2'd1;
  localparam logic [1:0] REQ_WBYTE   = 2'd2;
  localparam logic [1:0] REQ_RECOVER = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NACK    = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT = 2'd2;
  localparam logic [1:0] STAT_STUCK   = 2'd3;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       need_data;
    logic       need_msg;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/i2cm_fifo.sv
// Two-entry queue used on both sides of the engine.
// Depends on nothing beyond its WIDTH parameter.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && !empty) rptr <= ~rptr;
      count <= count + {1'b0, (wr && !full)} - {1'b0, (rd && !empty)};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !rd |=> full)
    else $error("queue lost an entry");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    empty |-> wptr == rptr)
    else $error("queue pointers disagree");

endmodule
`default_nettype wire

FILE: sv/i2cm_engine.sv
// Back end: bus sequencer that runs one transaction per enabled cycle.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_engine
  import i2cm_pkg::*;
#(
  parameter int unsigned LEN_WIDTH       = LEN_WIDTH_DEF,
  parameter int unsigned RECOVERY_PULSES = RECOVERY_PULSES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic [15:0]          bit_delay,
  input  wire logic [1:0]           req_type,
  input  wire logic                 scl_in,
  input  wire logic                 sda_in,
  input  wire logic [6:0]           slave_addr,
  input  wire logic                 msg_read,
  input  wire logic                 msg_restart,
  input  wire logic                 msg_stop,
  input  wire logic                 msg_last,
  input  wire logic [LEN_WIDTH-1:0] msg_len,
  input  wire logic [7:0]           tx_byte,
  output res_t                      res
);

  typedef enum logic [23:0] {
    PH_IDLE  = 24'h000001, PH_WMSG = 24'h000002, PH_WDATA = 24'h000004,
    PH_NEXT  = 24'h000008, PH_S0   = 24'h000010, PH_S1    = 24'h000020,
    PH_R0    = 24'h000040, PH_R1   = 24'h000080, PH_R2    = 24'h000100,
    PH_R3    = 24'h000200, PH_P0   = 24'h000400, PH_P1    = 24'h000800,
    PH_P2    = 24'h001000, PH_P3   = 24'h002000, PH_W0    = 24'h004000,
    PH_W1    = 24'h008000, PH_W2   = 24'h010000, PH_WB    = 24'h020000,
    PH_A0    = 24'h040000, PH_A1   = 24'h080000, PH_A2    = 24'h100000,
    PH_B0    = 24'h200000, PH_B1   = 24'h400000, PH_B2    = 24'h800000
  } phase_t;

  typedef enum logic [11:0] {
    ST_OPEN      = 12'h001, ST_PRE_STOP  = 12'h002, ST_PRE_GO   = 12'h004,
    ST_ADDR      = 12'h008, ST_WR        = 12'h010, ST_RD       = 12'h020,
    ST_RACK      = 12'h040, ST_CLOSE     = 12'h080, ST_REC_START = 12'h100,
    ST_REC_PULSE = 12'h200, ST_REC_RS    = 12'h400, ST_REC_STOP = 12'h800
  } stage_t;

  localparam logic [4:0] REC_LAST = 5'(RECOVERY_PULSES);

  phase_t               phase, phase_next;
  stage_t               stage, stage_next;
  logic [15:0]          tick_countdown, tick_countdown_next;
  logic [3:0]           bit_index, bit_index_next;
  logic [7:0]           shift_byte, shift_byte_next;
  logic [LEN_WIDTH-1:0] bytes_left, bytes_left_next;
  logic [8:0]           stretch_polls, stretch_polls_next;
  logic                 fl_read, fl_read_next;
  logic                 fl_stop, fl_stop_next;
  logic                 fl_last, fl_last_next;
  logic                 in_transfer, in_transfer_next;
  logic                 scl_drv, scl_drv_next;
  logic                 sda_drv, sda_drv_next;
  logic [1:0]           status_held, status_held_next;

  logic [15:0] half_up;
  logic [15:0] half_dn;
  logic        do_begin;
  logic        cont;
  logic        ev_rx;
  logic        ev_done;
  logic [1:0]  ev_status;

  assign half_up = 16'(({1'b0, bit_delay} + 17'd1) >> 1);
  assign half_dn = bit_delay >> 1;

  always_comb begin
    phase_next          = phase;
    stage_next          = stage;
    tick_countdown_next = tick_countdown;
    bit_index_next      = bit_index;
    shift_byte_next     = shift_byte;
    bytes_left_next     = bytes_left;
    stretch_polls_next  = stretch_polls;
    fl_read_next        = fl_read;
    fl_stop_next        = fl_stop;
    fl_last_next        = fl_last;
    in_transfer_next    = in_transfer;
    scl_drv_next        = scl_drv;
    sda_drv_next        = sda_drv;
    status_held_next    = status_held;
    do_begin            = 1'b0;
    cont                = 1'b0;
    ev_rx               = 1'b0;
    ev_done             = 1'b0;
    ev_status           = STAT_OK;

    case (req_type)
      REQ_TICK: begin
        if (phase != PH_IDLE && phase != PH_WMSG && phase != PH_WDATA) begin
          if (tick_countdown > 16'd1) begin
            tick_countdown_next = tick_countdown - 16'd1;
          end else begin
            case (phase)
              PH_NEXT: begin
                case (stage)
                  ST_OPEN: begin
                    if (fl_stop) begin
                      stage_next = ST_PRE_STOP; phase_next = PH_P0;
                    end else begin
                      bit_index_next = 4'd0; stage_next = ST_ADDR; phase_next = PH_W0;
                    end
                    cont = 1'b1;
                  end
                  ST_PRE_STOP: begin
                    if (!fl_last) begin
                      stage_next = ST_PRE_GO; phase_next = PH_S0;
                    end else begin
                      bit_index_next = 4'd0; stage_next = ST_ADDR; phase_next = PH_W0;
                    end
                    cont = 1'b1;
                  end
                  ST_PRE_GO: begin
                    bit_index_next = 4'd0; stage_next = ST_ADDR; phase_next = PH_W0;
                    cont = 1'b1;
                  end
                  ST_ADDR, ST_WR: begin
                    if (status_held != STAT_OK) begin
                      stage_next = ST_CLOSE; phase_next = PH_P0; cont = 1'b1;
                    end else begin
                      if (stage == ST_WR && bytes_left != '0) begin
                        bytes_left_next = bytes_left - 1'b1;
                      end
                      do_begin = 1'b1;
                    end
                  end
                  ST_REC_START: begin
                    bit_index_next = 4'd0; stage_next = ST_REC_PULSE; phase_next = PH_W0;
                    cont = 1'b1;
                  end
                  ST_REC_RS: begin
                    stage_next = ST_REC_STOP; phase_next = PH_P0; cont = 1'b1;
                  end
                  ST_CLOSE, ST_REC_STOP: begin
                    ev_done = 1'b1;
                    if (stage == ST_CLOSE) ev_status = status_held;
                    else ev_status = sda_in ? STAT_OK : STAT_STUCK;
                    phase_next = PH_IDLE; stage_next = ST_OPEN; in_transfer_next = 1'b0;
                  end
                  default: begin
                    ev_done = 1'b1;
                    phase_next = PH_IDLE; stage_next = ST_OPEN; in_transfer_next = 1'b0;
                  end
                endcase
              end
              PH_WB: begin
                if (stage == ST_REC_PULSE) begin
                  if ({1'b0, bit_index} + 5'd1 >= REC_LAST) begin
                    stage_next = ST_REC_RS; phase_next = PH_R0;
                  end else begin
                    bit_index_next = bit_index + 4'd1; phase_next = PH_W0;
                  end
                  cont = 1'b1;
                end else if (stage == ST_RACK) begin
                  do_begin = 1'b1;
                end else begin
                  shift_byte_next = {shift_byte[6:0], 1'b0};
                  bit_index_next  = bit_index + 4'd1;
                  phase_next = (bit_index_next >= 4'd8) ? PH_A0 : PH_W0;
                  cont = 1'b1;
                end
              end
              PH_A2: begin
                if (scl_in) begin
                  status_held_next = sda_in ? STAT_NACK : STAT_OK;
                  scl_drv_next = 1'b0; tick_countdown_next = half_dn; phase_next = PH_NEXT;
                end else if (stretch_polls[8]) begin
                  status_held_next = STAT_TIMEOUT;
                  stage_next = ST_CLOSE; phase_next = PH_P0; cont = 1'b1;
                end else begin
                  stretch_polls_next = stretch_polls + 9'd1;
                  tick_countdown_next = 16'd0;
                end
              end
              default: cont = 1'b1;
            endcase

            if (do_begin) begin
              if (bytes_left_next == '0) begin
                if (fl_last) begin
                  stage_next = ST_CLOSE; phase_next = PH_P0; cont = 1'b1;
                end else begin
                  phase_next = PH_WMSG;
                end
              end else if (fl_read) begin
                shift_byte_next = 8'd0; bit_index_next = 4'd0;
                stage_next = ST_RD; phase_next = PH_B0; cont = 1'b1;
              end else begin
                phase_next = PH_WDATA;
              end
            end

            if (cont) begin
              case (phase_next)
                PH_S0: begin
                  sda_drv_next = 1'b0; tick_countdown_next = bit_delay; phase_next = PH_S1;
                end
                PH_S1: begin
                  scl_drv_next = 1'b0; tick_countdown_next = half_dn; phase_next = PH_NEXT;
                end
                PH_R0: begin
                  sda_drv_next = 1'b1; tick_countdown_next = half_up; phase_next = PH_R1;
                end
                PH_R1: begin
                  scl_drv_next = 1'b1; tick_countdown_next = bit_delay; phase_next = PH_R2;
                end
                PH_R2: begin
                  sda_drv_next = 1'b0; tick_countdown_next = bit_delay; phase_next = PH_R3;
                end
                PH_R3: begin
                  scl_drv_next = 1'b0; tick_countdown_next = half_dn; phase_next = PH_NEXT;
                end
                PH_P0: begin
                  sda_drv_next = 1'b0; tick_countdown_next = half_up; phase_next = PH_P1;
                end
                PH_P1: begin
                  scl_drv_next = 1'b1; tick_countdown_next = bit_delay; phase_next = PH_P2;
                end
                PH_P2: begin
                  tick_countdown_next = half_up; phase_next = PH_P3;
                end
                PH_P3: begin
                  sda_drv_next = 1'b1; tick_countdown_next = bit_delay; phase_next = PH_NEXT;
                end
                PH_W0: begin
                  if (stage_next == ST_REC_PULSE) sda_drv_next = 1'b1;
                  else if (stage_next == ST_RACK) sda_drv_next = (bytes_left_next == '0);
                  else sda_drv_next = shift_byte_next[7];
                  tick_countdown_next = half_up; phase_next = PH_W1;
                end
                PH_W1: begin
                  scl_drv_next = 1'b1; tick_countdown_next = bit_delay; phase_next = PH_W2;
                end
                PH_W2: begin
                  scl_drv_next = 1'b0; tick_countdown_next = half_dn; phase_next = PH_WB;
                end
                PH_A0: begin
                  sda_drv_next = 1'b1; tick_countdown_next = half_up; phase_next = PH_A1;
                end
                PH_A1: begin
                  scl_drv_next = 1'b1; tick_countdown_next = bit_delay;
                  stretch_polls_next = 9'd0; phase_next = PH_A2;
                end
                PH_B0: begin
                  sda_drv_next = 1'b1; tick_countdown_next = half_up; phase_next = PH_B1;
                end
                PH_B1: begin
                  scl_drv_next = 1'b1; tick_countdown_next = bit_delay; phase_next = PH_B2;
                end
                PH_B2: begin
                  shift_byte_next = {shift_byte[6:0], sda_in};
                  scl_drv_next = 1'b0; tick_countdown_next = half_dn;
                  bit_index_next = bit_index + 4'd1;
                  if (bit_index_next >= 4'd8) begin
                    ev_rx = 1'b1;
                    if (bytes_left != '0) bytes_left_next = bytes_left - 1'b1;
                    stage_next = ST_RACK; phase_next = PH_W0;
                  end else begin
                    phase_next = PH_B1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      REQ_MSG: begin
        if (phase == PH_IDLE || phase == PH_WMSG) begin
          fl_read_next = msg_read; fl_stop_next = msg_stop; fl_last_next = msg_last;
          shift_byte_next = {slave_addr, msg_read};
          bytes_left_next = msg_len;
          tick_countdown_next = 16'd0;
          if (phase == PH_IDLE) begin
            in_transfer_next = 1'b1; status_held_next = STAT_OK;
            stage_next = ST_OPEN; phase_next = PH_S0;
          end else if (msg_restart) begin
            stage_next = ST_PRE_GO; phase_next = PH_R0;
          end else if (msg_stop) begin
            stage_next = ST_PRE_STOP; phase_next = PH_P0;
          end else begin
            bit_index_next = 4'd0; stage_next = ST_ADDR; phase_next = PH_W0;
          end
        end
      end
      REQ_WBYTE: begin
        if (phase == PH_WDATA) begin
          shift_byte_next = tx_byte; bit_index_next = 4'd0; tick_countdown_next = 16'd0;
          stage_next = ST_WR; phase_next = PH_W0;
        end
      end
      REQ_RECOVER: begin
        if (phase == PH_IDLE) begin
          status_held_next = STAT_OK; in_transfer_next = 1'b0; tick_countdown_next = 16'd0;
          stage_next = ST_REC_START; phase_next = PH_S0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.scl_drive = scl_drv_next;
    res.sda_drive = sda_drv_next;
    res.busy_res  = (phase_next != PH_IDLE);
    res.need_data = (phase_next == PH_WDATA);
    res.need_msg  = (phase_next == PH_WMSG) || (phase_next == PH_IDLE);
    res.rx_valid  = ev_rx;
    res.rx_byte   = ev_rx ? shift_byte_next : 8'd0;
    res.done_res  = ev_done;
    res.status    = ev_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      stage          <= ST_OPEN;
      tick_countdown <= 16'd0;
      bit_index      <= 4'd0;
      shift_byte     <= 8'd0;
      bytes_left     <= '0;
      stretch_polls  <= 9'd0;
      fl_read        <= 1'b0;
      fl_stop        <= 1'b0;
      fl_last        <= 1'b0;
      in_transfer    <= 1'b0;
      scl_drv        <= 1'b1;
      sda_drv        <= 1'b1;
      status_held    <= STAT_OK;
    end else if (en) begin
      phase          <= phase_next;
      stage          <= stage_next;
      tick_countdown <= tick_countdown_next;
      bit_index      <= bit_index_next;
      shift_byte     <= shift_byte_next;
      bytes_left     <= bytes_left_next;
      stretch_polls  <= stretch_polls_next;
      fl_read        <= fl_read_next;
      fl_stop        <= fl_stop_next;
      fl_last        <= fl_last_next;
      in_transfer    <= in_transfer_next;
      scl_drv        <= scl_drv_next;
      sda_drv        <= sda_drv_next;
      status_held    <= status_held_next;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    en && res.done_res |-> !res.busy_res)
    else $error("done reported while busy");
  a_rx_busy: assert property (@(posedge clk) disable iff (rst)
    en && res.rx_valid |-> res.busy_res && !res.done_res)
    else $error("byte received outside a transfer");
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    en && res.status != STAT_OK |-> res.done_res)
    else $error("status without done");
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    en && res.done_res |=> scl_drv && sda_drv && !in_transfer)
    else $error("bus not released after done");

endmodule
`default_nettype wire

FILE: sv/i2c_master_transfer_engine.sv
// Top level of the I2C master transfer engine.
// Depends on i2cm_pkg, i2cm_fifo and i2cm_engine.
//
// Each transaction (tick, message command, write byte or recovery request) yields
// exactly one result transaction. Requests go into a two-entry queue, the sequencer
// retires one per clock when a request waits and the result queue has room; results
// land in a two-entry queue, so with pop held high a new request is taken every
// clock and its result is on the result ports in the cycle after it is taken.
// bit_delay may only be written while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_transfer_engine
  import i2cm_pkg::*;
#(
  parameter int unsigned LEN_WIDTH       = LEN_WIDTH_DEF,
  parameter int unsigned RECOVERY_PULSES = RECOVERY_PULSES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [15:0]          cfg_wr_data,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [1:0]           req_type,
  input  wire logic                 scl_in,
  input  wire logic                 sda_in,
  input  wire logic [6:0]           slave_addr,
  input  wire logic                 msg_read,
  input  wire logic                 msg_restart,
  input  wire logic                 msg_stop,
  input  wire logic                 msg_last,
  input  wire logic [LEN_WIDTH-1:0] msg_len,
  input  wire logic [7:0]           tx_byte,
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      scl_drive,
  output logic                      sda_drive,
  output logic                      busy_res,
  output logic                      need_data,
  output logic                      need_msg,
  output logic                      rx_valid,
  output logic [7:0]                rx_byte,
  output logic                      done_res,
  output logic [1:0]                status
);

  localparam int unsigned REQ_W = 2 + 1 + 1 + 7 + 4 + LEN_WIDTH + 8;
  localparam int unsigned RES_W = $bits(res_t);

  logic [15:0]          bit_delay;
  logic [REQ_W-1:0]     req_q;
  logic                 req_empty;
  logic                 res_full;
  logic                 fire;
  res_t                 res_in;
  logic [RES_W-1:0]     res_q;
  res_t                 res_out;

  logic [1:0]           q_type;
  logic                 q_scl;
  logic                 q_sda;
  logic [6:0]           q_addr;
  logic                 q_read;
  logic                 q_restart;
  logic                 q_stop;
  logic                 q_last;
  logic [LEN_WIDTH-1:0] q_len;
  logic [7:0]           q_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_delay <= BIT_DELAY_RESET;
    end else if (cfg_wr_en) begin
      bit_delay <= cfg_wr_data;
    end
  end

  i2cm_fifo #(.WIDTH(REQ_W)) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata ({req_type, scl_in, sda_in, slave_addr, msg_read, msg_restart, msg_stop,
             msg_last, msg_len, tx_byte}),
    .full  (full),
    .rd    (fire),
    .rdata (req_q),
    .empty (req_empty)
  );

  assign {q_type, q_scl, q_sda, q_addr, q_read, q_restart, q_stop, q_last, q_len,
          q_byte} = req_q;

  assign fire = !req_empty && !res_full;

  i2cm_engine #(
    .LEN_WIDTH       (LEN_WIDTH),
    .RECOVERY_PULSES (RECOVERY_PULSES)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .en          (fire),
    .bit_delay   (bit_delay),
    .req_type    (q_type),
    .scl_in      (q_scl),
    .sda_in      (q_sda),
    .slave_addr  (q_addr),
    .msg_read    (q_read),
    .msg_restart (q_restart),
    .msg_stop    (q_stop),
    .msg_last    (q_last),
    .msg_len     (q_len),
    .tx_byte     (q_byte),
    .res         (res_in)
  );

  i2cm_fifo #(.WIDTH(RES_W)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (fire),
    .wdata (res_in),
    .full  (res_full),
    .rd    (pop),
    .rdata (res_q),
    .empty (empty)
  );

  assign res_out   = res_t'(res_q);
  assign scl_drive = res_out.scl_drive;
  assign sda_drive = res_out.sda_drive;
  assign busy_res  = res_out.busy_res;
  assign need_data = res_out.need_data;
  assign need_msg  = res_out.need_msg;
  assign rx_valid  = res_out.rx_valid;
  assign rx_byte   = res_out.rx_byte;
  assign done_res  = res_out.done_res;
  assign status    = res_out.status;

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the I2C master transfer engine.
// Depends on i2cm_pkg and the i2c_master_transfer_engine RTL; a built-in predictor
// follows every transaction and the results are checked in order.
`timescale 1ns / 1ps
module testbench;
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WMSG, PH_WDATA, PH_NEXT, PH_S0, PH_S1,
    PH_R0, PH_R1, PH_R2, PH_R3, PH_P0, PH_P1, PH_P2, PH_P3,
    PH_W0, PH_W1, PH_W2, PH_WB, PH_A0, PH_A1, PH_A2,
    PH_B0, PH_B1, PH_B2
  } bus_phase_e;

  typedef enum logic [3:0] {
    SG_OPEN, SG_PRE_STOP, SG_PRE_GO, SG_ADDR, SG_WR, SG_RD, SG_RACK,
    SG_CLOSE, SG_REC_START, SG_REC_PULSE, SG_REC_RS, SG_REC_STOP
  } seq_stage_e;

  typedef struct {
    logic [1:0]  req;
    logic        scl;
    logic        sda;
    logic [6:0]  addr;
    logic        rd;
    logic        rs;
    logic        stp;
    logic        last;
    logic [15:0] len;
    logic [7:0]  txb;
  } request_t;

  localparam int STRETCH_LIMIT = 256;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  req_type = REQ_TICK;
  logic        scl_in = 1'b1;
  logic        sda_in = 1'b1;
  logic [6:0]  slave_addr = '0;
  logic        msg_read = 1'b0;
  logic        msg_restart = 1'b0;
  logic        msg_stop = 1'b0;
  logic        msg_last = 1'b0;
  logic [15:0] msg_len = '0;
  logic [7:0]  tx_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        scl_drive, sda_drive, busy_res, need_data, need_msg, rx_valid;
  logic [7:0]  rx_byte;
  logic        done_res;
  logic [1:0]  status;

  i2c_master_transfer_engine dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .push(push), .full(full),
    .req_type(req_type), .scl_in(scl_in), .sda_in(sda_in),
    .slave_addr(slave_addr), .msg_read(msg_read), .msg_restart(msg_restart),
    .msg_stop(msg_stop), .msg_last(msg_last), .msg_len(msg_len), .tx_byte(tx_byte),
    .empty(empty), .pop(pop),
    .scl_drive(scl_drive), .sda_drive(sda_drive), .busy_res(busy_res),
    .need_data(need_data), .need_msg(need_msg), .rx_valid(rx_valid),
    .rx_byte(rx_byte), .done_res(done_res), .status(status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Engine mirror
  logic [15:0] bus_delay;
  bus_phase_e  ph;
  seq_stage_e  stg;
  logic [15:0] wait_cnt;
  logic [3:0]  bit_pos;
  logic [7:0]  shreg;
  logic [15:0] bytes_left;
  logic [8:0]  polls;
  logic        fl_read, fl_stop, fl_last;
  logic        scl_o, sda_o;
  logic [1:0]  held_status;
  logic        ev_rx, ev_done;
  logic [7:0]  ev_byte;
  logic [1:0]  ev_status;

  request_t pending[$];
  res_t     expected_results[$];
  int       n_generated, n_accepted, n_checked, n_mismatch;
  int       n_transfers, n_recoveries, n_rx_bytes;
  int       n_status[4];
  bit       quiet;
  int       msgs_left;
  int       len_override;
  int       pin_mode;  // 0 normal, 1 force NACK, 2 hold SCL low in the ACK poll

  function automatic logic [15:0] half_up();
    return 16'((17'(bus_delay) + 17'd1) >> 1);
  endfunction

  function automatic bit go(seq_stage_e s, bus_phase_e p);
    stg = s;
    ph = p;
    return 1'b1;
  endfunction

  function automatic bit start_addr();
    bit_pos = '0;
    return go(SG_ADDR, PH_W0);
  endfunction

  function automatic bit finish(logic [1:0] st);
    ev_done = 1'b1;
    ev_status = st;
    ph = PH_IDLE;
    stg = SG_OPEN;
    return 1'b0;
  endfunction

  function automatic bit begin_data();
    if (bytes_left == 0) begin
      if (fl_last) return go(SG_CLOSE, PH_P0);
      ph = PH_WMSG;
      return 1'b0;
    end
    if (fl_read) begin
      shreg = '0;
      bit_pos = '0;
      return go(SG_RD, PH_B0);
    end
    ph = PH_WDATA;
    return 1'b0;
  endfunction

  function automatic bit dispatch(logic sda);
    case (stg)
      SG_OPEN: begin
        if (fl_stop) return go(SG_PRE_STOP, PH_P0);
        return start_addr();
      end
      SG_PRE_STOP: begin
        if (!fl_last) return go(SG_PRE_GO, PH_S0);
        return start_addr();
      end
      SG_PRE_GO: return start_addr();
      SG_ADDR: begin
        if (held_status != STAT_OK) return go(SG_CLOSE, PH_P0);
        return begin_data();
      end
      SG_WR: begin
        if (held_status != STAT_OK) return go(SG_CLOSE, PH_P0);
        if (bytes_left != 0) bytes_left--;
        return begin_data();
      end
      SG_CLOSE: return finish(held_status);
      SG_REC_START: begin
        bit_pos = '0;
        return go(SG_REC_PULSE, PH_W0);
      end
      SG_REC_RS: return go(SG_REC_STOP, PH_P0);
      SG_REC_STOP: return finish(sda ? STAT_OK : STAT_STUCK);
      default: return finish(STAT_OK);
    endcase
  endfunction

  function automatic bit bus_action(logic scl, logic sda);
    logic b;
    case (ph)
      PH_S0: begin sda_o = 0; wait_cnt = bus_delay; ph = PH_S1; end
      PH_S1: begin scl_o = 0; wait_cnt = bus_delay >> 1; ph = PH_NEXT; end
      PH_R0: begin sda_o = 1; wait_cnt = half_up(); ph = PH_R1; end
      PH_R1: begin scl_o = 1; wait_cnt = bus_delay; ph = PH_R2; end
      PH_R2: begin sda_o = 0; wait_cnt = bus_delay; ph = PH_R3; end
      PH_R3: begin scl_o = 0; wait_cnt = bus_delay >> 1; ph = PH_NEXT; end
      PH_P0: begin sda_o = 0; wait_cnt = half_up(); ph = PH_P1; end
      PH_P1: begin scl_o = 1; wait_cnt = bus_delay; ph = PH_P2; end
      PH_P2: begin wait_cnt = half_up(); ph = PH_P3; end
      PH_P3: begin sda_o = 1; wait_cnt = bus_delay; ph = PH_NEXT; end
      PH_W0: begin
        if (stg == SG_REC_PULSE) b = 1'b1;
        else if (stg == SG_RACK) b = (bytes_left == 0);
        else b = shreg[7];
        sda_o = b;
        wait_cnt = half_up();
        ph = PH_W1;
      end
      PH_W1: begin scl_o = 1; wait_cnt = bus_delay; ph = PH_W2; end
      PH_W2: begin scl_o = 0; wait_cnt = bus_delay >> 1; ph = PH_WB; end
      PH_WB: begin
        if (stg == SG_REC_PULSE) begin
          if (int'(bit_pos) + 1 >= RECOVERY_PULSES_DEF) return go(SG_REC_RS, PH_R0);
          bit_pos++;
          ph = PH_W0;
          return 1'b1;
        end
        if (stg == SG_RACK) return begin_data();
        shreg = shreg << 1;
        bit_pos++;
        ph = (bit_pos >= 8) ? PH_A0 : PH_W0;
        return 1'b1;
      end
      PH_A0: begin sda_o = 1; wait_cnt = half_up(); ph = PH_A1; end
      PH_A1: begin scl_o = 1; wait_cnt = bus_delay; polls = '0; ph = PH_A2; end
      PH_A2: begin
        if (scl) begin
          held_status = sda ? STAT_NACK : STAT_OK;
          scl_o = 0;
          wait_cnt = bus_delay >> 1;
          ph = PH_NEXT;
          return 1'b0;
        end
        if (polls >= STRETCH_LIMIT) begin
          held_status = STAT_TIMEOUT;
          return go(SG_CLOSE, PH_P0);
        end
        polls++;
        wait_cnt = '0;
      end
      PH_B0: begin sda_o = 1; wait_cnt = half_up(); ph = PH_B1; end
      PH_B1: begin scl_o = 1; wait_cnt = bus_delay; ph = PH_B2; end
      PH_B2: begin
        shreg = {shreg[6:0], sda};
        scl_o = 0;
        wait_cnt = bus_delay >> 1;
        bit_pos++;
        if (bit_pos >= 8) begin
          ev_rx = 1'b1;
          ev_byte = shreg;
          if (bytes_left != 0) bytes_left--;
          stg = SG_RACK;
          ph = PH_W0;
        end else begin
          ph = PH_B1;
        end
      end
      PH_NEXT: return dispatch(sda);
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void latch_message(request_t r);
    fl_read = r.rd;
    fl_stop = r.stp;
    fl_last = r.last;
    shreg = {r.addr, r.rd};
    bytes_left = r.len;
    wait_cnt = '0;
  endfunction

  function automatic res_t engine_step(request_t r);
    res_t o;
    ev_rx = 0; ev_byte = '0; ev_done = 0; ev_status = STAT_OK;
    case (r.req)
      REQ_TICK: begin
        if (!(ph inside {PH_IDLE, PH_WMSG, PH_WDATA})) begin
          if (wait_cnt > 1) wait_cnt--;
          else while (bus_action(r.scl, r.sda)) ;
        end
      end
      REQ_MSG: begin
        if (ph == PH_IDLE) begin
          latch_message(r);
          held_status = STAT_OK;
          stg = SG_OPEN;
          ph = PH_S0;
        end else if (ph == PH_WMSG) begin
          latch_message(r);
          if (r.rs) begin stg = SG_PRE_GO; ph = PH_R0; end
          else if (fl_stop) begin stg = SG_PRE_STOP; ph = PH_P0; end
          else begin bit_pos = '0; stg = SG_ADDR; ph = PH_W0; end
        end
      end
      REQ_WBYTE: begin
        if (ph == PH_WDATA) begin
          shreg = r.txb;
          bit_pos = '0;
          wait_cnt = '0;
          stg = SG_WR;
          ph = PH_W0;
        end
      end
      default: begin
        if (ph == PH_IDLE) begin
          held_status = STAT_OK;
          wait_cnt = '0;
          stg = SG_REC_START;
          ph = PH_S0;
        end
      end
    endcase
    o.scl_drive = scl_o;
    o.sda_drive = sda_o;
    o.busy_res = (ph != PH_IDLE);
    o.need_data = (ph == PH_WDATA);
    o.need_msg = (ph == PH_WMSG || ph == PH_IDLE);
    o.rx_valid = ev_rx;
    o.rx_byte = ev_byte;
    o.done_res = ev_done;
    o.status = ev_status;
    return o;
  endfunction

  task automatic enqueue(request_t r);
    res_t o;
    o = engine_step(r);
    if (o.done_res) begin
      n_status[o.status]++;
      if (stg == SG_OPEN && r.req == REQ_TICK) n_transfers++;
    end
    if (o.rx_valid) n_rx_bytes++;
    expected_results.push_back(o);
    pending.push_back(r);
    n_generated++;
  endtask

  function automatic request_t random_request();
    request_t r;
    r.req = 2'($urandom_range(0, 3));
    r.scl = 1'($urandom_range(0, 1));
    r.sda = 1'($urandom_range(0, 1));
    r.addr = 7'($urandom_range(0, 127));
    r.rd = 1'($urandom_range(0, 1));
    r.rs = 1'($urandom_range(0, 1));
    r.stp = 1'($urandom_range(0, 1));
    r.last = 1'($urandom_range(0, 1));
    r.len = 16'($urandom_range(0, 65535));
    r.txb = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic request_t message_request();
    request_t r;
    r = random_request();
    r.req = REQ_MSG;
    r.rs = ($urandom_range(0, 2) == 0);
    r.stp = ($urandom_range(0, 3) == 0);
    r.last = (msgs_left <= 1);
    if (len_override >= 0) begin
      r.len = 16'(len_override);
      len_override = -1;
    end else begin
      r.len = 16'($urandom_range(0, 3));
    end
    msgs_left--;
    return r;
  endfunction

  function automatic request_t tick_request();
    request_t r;
    r = random_request();
    r.req = REQ_TICK;
    if (ph == PH_A2) begin
      r.scl = (pin_mode == 2) ? 1'b0 : ($urandom_range(0, 4) != 0);
      r.sda = (pin_mode == 1) ? 1'b1 : ($urandom_range(0, 7) == 0);
    end else begin
      r.scl = ($urandom_range(0, 9) != 0);
    end
    return r;
  endfunction

  // Run a transaction sequence from a message command or recovery until idle.
  task automatic run_sequence(bit recover, int nmsg, bit noisy);
    request_t r;
    int guard;
    msgs_left = nmsg;
    if (recover) begin
      r = random_request();
      r.req = REQ_RECOVER;
      n_recoveries++;
    end else begin
      r = message_request();
    end
    enqueue(r);
    guard = 0;
    while (ph != PH_IDLE && guard < 20000) begin
      if (noisy && $urandom_range(0, 39) == 0) begin
        r = random_request();
        r.len = 16'($urandom_range(0, 3));
      end else if (ph == PH_WDATA) begin
        r = random_request();
        r.req = REQ_WBYTE;
      end else if (ph == PH_WMSG) r = message_request();
      else r = tick_request();
      enqueue(r);
      guard++;
    end
    pin_mode = 0;
  endtask

  task automatic write_delay(logic [15:0] d);
    wait (pending.size() == 0 && expected_results.size() == 0);
    repeat (4) @(negedge clk);
    cfg_wr_data = d;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    bus_delay = d;
  endtask

  initial begin
    request_t r;
    int k;
    bus_delay = BIT_DELAY_RESET;
    ph = PH_IDLE; stg = SG_OPEN; wait_cnt = '0; bit_pos = '0; shreg = '0;
    bytes_left = '0; polls = '0; fl_read = 0; fl_stop = 0; fl_last = 0;
    scl_o = 1; sda_o = 1; held_status = STAT_OK;
    len_override = -1;
    pin_mode = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle noise, short messages, zero length, aborts, recovery
    r = random_request(); r.req = REQ_TICK; r.scl = 0; r.sda = 0; enqueue(r);
    r.scl = 1; r.sda = 1; enqueue(r);
    r.req = REQ_WBYTE; r.txb = 8'hFF; enqueue(r);
    len_override = 1;
    run_sequence(0, 1, 0);
    write_delay(16'd0);
    len_override = 2; run_sequence(0, 2, 0);
    len_override = 0; run_sequence(0, 3, 0);
    pin_mode = 1; len_override = 65535; run_sequence(0, 1, 0);
    pin_mode = 2; run_sequence(0, 1, 0);
    run_sequence(1, 0, 0);
    write_delay(16'd65535);
    r = random_request(); r.req = REQ_TICK; enqueue(r);
    r.req = REQ_WBYTE; r.txb = 8'h00; enqueue(r);
    write_delay(16'd1);
    run_sequence(1, 0, 0);

    // random phases with small delays
    k = 0;
    while (n_generated < 1450) begin
      if (k % 6 == 5) write_delay(16'($urandom_range(0, 3)));
      if (n_generated > 1250) quiet = 1'b1;
      pin_mode = ($urandom_range(0, 11) == 0) ? 2 : ($urandom_range(0, 9) == 0);
      run_sequence($urandom_range(0, 7) == 0, $urandom_range(1, 4), 1);
      k++;
    end

    wait (pending.size() == 0 && expected_results.size() == 0);
    repeat (10) @(posedge clk);
    $display("Ran %0d transactions, %0d results checked, %0d mismatches.",
             n_accepted, n_checked, n_mismatch);
    $display("Sequences: %0d recoveries, %0d bytes read, endings ok/nack/timeout/stuck %0d/%0d/%0d/%0d",
             n_recoveries, n_rx_bytes, n_status[0], n_status[1], n_status[2], n_status[3]);
    if (n_mismatch == 0) begin
      $display("** i2c_master_transfer_engine: PASSED **");
    end else begin
      $display("** i2c_master_transfer_engine: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("** i2c_master_transfer_engine: FAILED **");
    $finish;
  end

  // Driver
  int send_gap, recv_gap;
  always @(negedge clk) begin
    if (!rst) begin
      if (send_gap > 0) begin
        send_gap--;
        push = 1'b0;
      end else if (!quiet && $urandom_range(0, 29) == 0) begin
        send_gap = $urandom_range(1, 19);
        push = 1'b0;
      end else if (pending.size() > 0) begin
        req_type = pending[0].req;
        scl_in = pending[0].scl;
        sda_in = pending[0].sda;
        slave_addr = pending[0].addr;
        msg_read = pending[0].rd;
        msg_restart = pending[0].rs;
        msg_stop = pending[0].stp;
        msg_last = pending[0].last;
        msg_len = pending[0].len;
        tx_byte = pending[0].txb;
        push = 1'b1;
      end else begin
        push = 1'b0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        pop = 1'b0;
      end else if (!quiet && $urandom_range(0, 29) == 0) begin
        recv_gap = $urandom_range(1, 19);
        pop = 1'b0;
      end else begin
        pop = 1'b1;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    res_t got, want;
    if (!rst) begin
      if (push && !full) begin
        pending.pop_front();
        n_accepted++;
      end
      if (pop && !empty) begin
        got = '{scl_drive, sda_drive, busy_res, need_data, need_msg, rx_valid,
                rx_byte, done_res, status};
        if (expected_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("Unexpected result transaction: %p", got);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("Mismatch on result %0d: expected %p, actual %p", n_checked, want, got);
          end
        end
      end
    end
  end

endmodule
